### hdl/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hdl/aism_pkg.sv
// -----------------------------------------------------------------------------
// aism_pkg
// Types, inverse S-box table and GF(2^8) helpers for the inverse column path.
// -----------------------------------------------------------------------------
package aism_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [31:0] column_t;

    localparam int unsigned NUM_BYTES = 4;
    localparam byte_t       GF_POLY   = 8'h1B;

    localparam byte_t INV_SBOX [256] = '{
        8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,
        8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
        8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,
        8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
        8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,
        8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
        8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,
        8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
        8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,
        8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
        8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,
        8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
        8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,
        8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
        8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,
        8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
        8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,
        8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
        8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,
        8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
        8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,
        8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
        8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,
        8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
        8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,
        8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
        8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,
        8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
        8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,
        8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,
        8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
    };

    function automatic byte_t xtime(input byte_t b);
        return b[7] ? ({b[6:0], 1'b0} ^ GF_POLY) : {b[6:0], 1'b0};
    endfunction

    function automatic byte_t mul09(input byte_t b);
        byte_t b2, b4, b8;
        b2 = xtime(b);
        b4 = xtime(b2);
        b8 = xtime(b4);
        return b8 ^ b;
    endfunction

    function automatic byte_t mul0b(input byte_t b);
        byte_t b2, b4, b8;
        b2 = xtime(b);
        b4 = xtime(b2);
        b8 = xtime(b4);
        return b8 ^ b2 ^ b;
    endfunction

    function automatic byte_t mul0d(input byte_t b);
        byte_t b2, b4, b8;
        b2 = xtime(b);
        b4 = xtime(b2);
        b8 = xtime(b4);
        return b8 ^ b4 ^ b;
    endfunction

    function automatic byte_t mul0e(input byte_t b);
        byte_t b2, b4, b8;
        b2 = xtime(b);
        b4 = xtime(b2);
        b8 = xtime(b4);
        return b8 ^ b4 ^ b2;
    endfunction

endpackage

### hdl/aism_sbox_rom.sv
// -----------------------------------------------------------------------------
// aism_sbox_rom
// Inverse S-box ROM, one byte lookup with registered read data.
// -----------------------------------------------------------------------------
module aism_sbox_rom (
    input  logic           aclk,
    input  logic           rd_en,
    input  aism_pkg::byte_t rd_addr,
    output aism_pkg::byte_t rd_data
);
    import aism_pkg::*;

    byte_t rom_mem [256];
    byte_t rd_data_reg;

    assign rom_mem = INV_SBOX;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= rom_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/aism_mix.sv
// -----------------------------------------------------------------------------
// aism_mix
// InvMixColumns matrix product of one substituted column over GF(2^8).
// -----------------------------------------------------------------------------
module aism_mix (
    input  aism_pkg::column_t col_in,
    output aism_pkg::column_t col_out
);
    import aism_pkg::*;

    byte_t s0, s1, s2, s3;
    byte_t r0, r1, r2, r3;

    assign {s0, s1, s2, s3} = col_in;

    always_comb begin
        r0 = mul0e(s0) ^ mul0b(s1) ^ mul0d(s2) ^ mul09(s3);
        r1 = mul09(s0) ^ mul0e(s1) ^ mul0b(s2) ^ mul0d(s3);
        r2 = mul0d(s0) ^ mul09(s1) ^ mul0e(s2) ^ mul0b(s3);
        r3 = mul0b(s0) ^ mul0d(s1) ^ mul09(s2) ^ mul0e(s3);
    end

    assign col_out = {r0, r1, r2, r3};

endmodule

### hdl/aes_inv_sub_mix_column.sv
// -----------------------------------------------------------------------------
// aes_inv_sub_mix_column
// Inverse S-box plus InvMixColumns on one 32-bit AES state column.
// -----------------------------------------------------------------------------
// Input channel s_valid/s_ready/s_column_in carries one column, byte 0 in
// bits 31..24. Output channel m_valid/m_ready/m_column_out returns the column
// after inverse substitution and InvMixColumns, same byte order, no key add.
// Pipeline: an accepted column passes the ROM stage, then the output register,
// before m_valid. Stage one reads four inverse S-box ROMs (synchronous read);
// stage two registers the GF(2^8) matrix product.
// Throughput: one item per cycle while m_ready is high.
// On a stall the output register and the ROM stage hold; s_ready drops once
// both are full and m_ready is low.
// Reset (aresetn low, synchronous) empties both stages; no state is kept
// between items, so results never depend on history.
// -----------------------------------------------------------------------------
module aes_inv_sub_mix_column (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_column_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_column_out
);
    import aism_pkg::*;

    `include "assert_macros.svh"

    logic    sub_valid_reg, sub_valid_next;
    logic    out_valid_reg, out_valid_next;
    column_t out_col_reg;
    column_t sub_col;
    column_t mix_col;
    logic    in_fire;
    logic    adv_out;
    logic    sub_stall;

    assign adv_out   = !out_valid_reg || m_ready;
    assign s_ready   = !sub_valid_reg || adv_out;
    assign in_fire   = s_valid && s_ready;
    assign sub_stall = sub_valid_reg && !adv_out;

    for (genvar i = 0; i < NUM_BYTES; i++) begin : g_rom
        aism_sbox_rom u_rom (
            .aclk    (aclk),
            .rd_en   (in_fire),
            .rd_addr (s_column_in[8*i +: 8]),
            .rd_data (sub_col[8*i +: 8])
        );
    end

    aism_mix u_mix (
        .col_in  (sub_col),
        .col_out (mix_col)
    );

    always_comb begin
        sub_valid_next = sub_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_ready) begin
            sub_valid_next = s_valid;
        end
        if (adv_out) begin
            out_valid_next = sub_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            sub_valid_reg <= sub_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_out && sub_valid_reg) begin
            out_col_reg <= mix_col;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_column_out = out_col_reg;

    `ASSERT_NEXT(a_accept_fills, aclk, aresetn, in_fire, sub_valid_reg, "accepted item lost")
    `ASSERT_NEXT(a_sub_moves, aclk, aresetn, sub_valid_reg && adv_out, out_valid_reg, "item lost")
    `ASSERT_NEXT(a_sub_holds, aclk, aresetn, sub_stall, sub_valid_reg, "stalled item lost")
    `ASSERT_NEXT(a_sub_stable, aclk, aresetn, sub_stall, $stable(sub_col), "stalled item changed")
    `ASSERT_SAME(a_ready_full, aclk, aresetn, sub_stall, !s_ready, "ready while full")

endmodule

### tb/tb_aes_inv_sub_mix_column.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_aes_inv_sub_mix_column
// Self-checking bench for the inverse S-box plus InvMixColumns column path.
// -----------------------------------------------------------------------------
// Columns go in through the valid/ready input channel: first a directed set,
// then random columns. Each accepted column is predicted by an independent
// model: the inverse S-box is derived from the GF(2^8) inverse and the affine
// map, and the matrix product is done by shift-and-add multiplication. Results
// are compared in order. Both sides idle at random, with burst stretches, and
// the receiver holds off once for a long stretch so the pipeline backs up.
// -----------------------------------------------------------------------------
module tb_aes_inv_sub_mix_column;

    import aism_pkg::*;

    localparam int RANDOM_COLUMNS = 1500;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int HOLD_AT_RESULT = 60;
    localparam int HOLD_CYCLES    = 200;

    class column_scoreboard;
        byte_t   inv_sub [256];
        byte_t   mix_coef [4];
        column_t pending_columns [$];
        int      errors;

        function new();
            byte_t x, inv, fwd;
            mix_coef = '{8'h0E, 8'h0B, 8'h0D, 8'h09};
            errors   = 0;
            for (int i = 0; i < 256; i++) begin
                x   = byte_t'(i);
                inv = 8'h00;
                if (x != 8'h00) begin
                    inv = 8'h01;
                    for (int k = 0; k < 254; k++) inv = gf_mul(inv, x);
                end
                fwd = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                    ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
                inv_sub[fwd] = x;
            end
        endfunction

        function byte_t gf_mul(input byte_t a, input byte_t b);
            byte_t acc;
            acc = 8'h00;
            for (int k = 0; k < 8; k++) begin
                if (b[k]) acc = acc ^ a;
                a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1B) : {a[6:0], 1'b0};
            end
            return acc;
        endfunction

        function column_t inv_round_column(input column_t col);
            byte_t   sub [4];
            byte_t   acc;
            column_t result;
            result = '0;
            for (int c = 0; c < 4; c++) sub[c] = inv_sub[col[31 - 8*c -: 8]];
            for (int r = 0; r < 4; r++) begin
                acc = 8'h00;
                for (int c = 0; c < 4; c++)
                    acc = acc ^ gf_mul(mix_coef[(c - r + 4) & 3], sub[c]);
                result[31 - 8*r -: 8] = acc;
            end
            return result;
        endfunction

        function void note_column(input column_t col);
            pending_columns.push_back(inv_round_column(col));
        endfunction

        function void check_column(input column_t actual);
            column_t want;
            if (pending_columns.size() == 0) begin
                $display("%0t: unexpected column, expected none, actual %08h",
                         $time, actual);
                errors++;
            end else begin
                want = pending_columns.pop_front();
                if (want !== actual) begin
                    $display("%0t: column_out mismatch, expected %08h, actual %08h",
                             $time, want, actual);
                    errors++;
                end
            end
        endfunction
    endclass

    logic    aclk = 1'b0;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    column_t s_column_in;
    logic    m_valid;
    logic    m_ready;
    column_t m_column_out;
    int      cycle_count = 0;

    column_scoreboard sb;

    aes_inv_sub_mix_column dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_column_in  (s_column_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_column_out (m_column_out)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL aes_inv_sub_mix_column");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_column(m_column_out);
    end

    function automatic int draw_gap(input int idx);
        return ((idx / 64) % 3 == 1) ? 0 : int'($urandom_range(0, 9));
    endfunction

    task automatic send_column(input column_t col, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_column_in <= col;
        do @(posedge aclk); while (!s_ready);
        sb.note_column(col);
    endtask

    function automatic byte_t pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h63;
            default: return byte_t'($urandom);
        endcase
    endfunction

    // receiver: random stalls, bursts, and one long hold-off
    initial begin
        int results;
        int gap;
        results = 0;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            gap = (results == HOLD_AT_RESULT) ? HOLD_CYCLES : draw_gap(results + 32);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results++;
        end
    end

    initial begin
        column_t directed [$];
        column_t col;
        sb = new();
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_column_in <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                     32'h6363_6363, 32'h5252_5252, 32'hFF00_FF00, 32'h00FF_00FF,
                     32'h0102_0304, 32'hDEAD_BEEF, 32'h8000_0080, 32'h7F7F_7F7F,
                     32'hAAAA_AAAA, 32'h5555_5555, 32'h6300_0000, 32'h0000_0063,
                     32'h1B1B_1B1B, 32'h0E0B_0D09, 32'h8080_8080, 32'h0101_0101};
        foreach (directed[i]) send_column(directed[i], draw_gap(i));

        for (int i = 0; i < RANDOM_COLUMNS; i++) begin
            if ($urandom_range(0, 3) == 0)
                col = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
            else
                col = column_t'($urandom);
            send_column(col, draw_gap(i));
        end
        s_valid <= 1'b0;

        while (sb.pending_columns.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("PASS aes_inv_sub_mix_column");
        end else begin
            $display("FAIL aes_inv_sub_mix_column");
        end
        $finish;
    end

endmodule
